@@ hdl/fqs_pkg.sv @@
package fqs_pkg;

  // Result range selection
  typedef enum logic [1:0] {
    MODE_S8  = 2'd0,
    MODE_S16 = 2'd1,
    MODE_S32 = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  // Stage 1 -> stage 2: unpacked operands and mantissa product
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;   // unbiased exponent sum, product in [1,4)
    logic [47:0] prod;         // 24x24 mantissa product, binary point at bit 46
  } s1_t;

  // Stage 2 -> stage 3: rounded single-precision product
  typedef struct packed {
    logic        nan;
    logic        big;          // |p| >= 2^31 (incl. infinity)
    logic        sign;
    logic signed [10:0] exp;   // unbiased exponent of rounded product
    logic [23:0] man;          // 1.23 mantissa, zero when product is zero/tiny
  } s2_t;

endpackage

@@ hdl/float_quantizer_saturating.sv @@
// Results are registered in s1_q, s2_q and res_q; done_o strobes with quantized_o valid.
// Throughput: one item per cycle; busy is never asserted and results cannot be stalled.
// Stages: operand unpack and 24x24 mantissa multiply, float rounding to
// nearest even, then integer rounding (half away from zero) and saturation.
// Reset clears the valid pipeline and sets the range mode to signed 8-bit.
module float_quantizer_saturating
  import fqs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        sample_bits_i,
  input  logic [31:0]        scale_bits_i,
  output logic               done_o,
  output logic signed [31:0] quantized_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);

  logic [1:0] mode_q;
  logic       v1_q, v2_q, v3_q;
  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q;
  logic signed [31:0] res_d, res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_S8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // Stage 1: unpack, normalize subnormals and multiply mantissas
  always_comb begin
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [23:0] ma, mb;
    logic        za, zb, ia, ib, na, nb;
    logic [4:0]  lza, lzb;
    ea = sample_bits_i[30:23]; fa = sample_bits_i[22:0];
    eb = scale_bits_i[30:23];  fb = scale_bits_i[22:0];
    za = (ea == 8'd0) && (fa == 23'd0);
    zb = (eb == 8'd0) && (fb == 23'd0);
    ia = (ea == 8'hFF) && (fa == 23'd0);
    ib = (eb == 8'hFF) && (fb == 23'd0);
    na = (ea == 8'hFF) && (fa != 23'd0);
    nb = (eb == 8'hFF) && (fb != 23'd0);
    ma = {(ea != 8'd0), fa};
    mb = {(eb != 8'd0), fb};
    // leading zeros of a subnormal mantissa (zero for normal operands)
    lza = '0; lzb = '0;
    for (int i = 0; i < 24; i++) begin
      if (ma[i]) lza = 5'(23 - i);
      if (mb[i]) lzb = 5'(23 - i);
    end
    ma = ma << lza;
    mb = mb << lzb;
    s1_d.nan  = na || nb || (ia && zb) || (ib && za);
    s1_d.inf  = ia || ib;
    s1_d.zero = za || zb;
    s1_d.sign = sample_bits_i[31] ^ scale_bits_i[31];
    // subnormals use exponent -126, lowered by the normalizing shift
    s1_d.exp  = $signed({3'b000, (ea == 8'd0) ? 8'd1 : ea})
              + $signed({3'b000, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd254
              - $signed({6'd0, lza}) - $signed({6'd0, lzb});
    s1_d.prod = ma * mb;
  end

  // Stage 2: normalize and round to single precision (nearest even)
  always_comb begin
    logic [47:0] p;
    logic signed [10:0] e;
    logic [23:0] m;
    logic        g, st;
    logic [24:0] mr;
    p = s1_q.prod;
    e = s1_q.exp;
    if (p[47]) begin
      m  = p[47:24]; g = p[23]; st = |p[22:0]; e = e + 11'sd1;
    end else begin
      m  = p[46:23]; g = p[22]; st = |p[21:0];
    end
    mr = {1'b0, m} + {24'd0, g && (st || m[0])};
    if (mr[24]) begin
      m = mr[24:1]; e = e + 11'sd1;
    end else begin
      m = mr[23:0];
    end
    s2_d.nan  = s1_q.nan;
    s2_d.sign = s1_q.sign;
    s2_d.exp  = e;
    // zero product or exp < -2 (below 0.25) rounds to zero
    s2_d.man  = (s1_q.zero || !m[23] || e < -11'sd2) ? 24'd0 : m;
    s2_d.big  = !s1_q.nan && (s1_q.inf || (!s1_q.zero && m[23] && e >= 11'sd31));
    if (s2_d.man == 24'd0) s2_d.exp = -11'sd2;
  end

  // Stage 3: round half away from zero and saturate (NaN gives zero)
  always_comb begin
    logic [55:0] sh;
    logic [31:0] mag;
    logic [32:0] r;
    logic signed [33:0] v;
    logic signed [33:0] lo, hi;
    sh  = {32'd0, s2_q.man} << (s2_q.exp + 11'sd2);
    // sh binary point at bit 25 (man has 23 frac bits, shifted by exp+2)
    mag = {1'b0, sh[55:25]};
    r   = {1'b0, mag} + {32'd0, sh[24]};
    v   = s2_q.sign ? -$signed({1'b0, r}) : $signed({1'b0, r});
    unique case (mode_e'(mode_q))
      MODE_S8:  begin lo = -34'sd128;        hi = 34'sd127;        end
      MODE_S16: begin lo = -34'sd32768;      hi = 34'sd32767;      end
      default:  begin lo = -34'sd2147483648; hi = 34'sd2147483647; end
    endcase
    if (s2_q.nan)          res_d = '0;
    else if (s2_q.big)     res_d = s2_q.sign ? lo[31:0] : hi[31:0];
    else if (v > hi)       res_d = hi[31:0];
    else if (v < lo)       res_d = lo[31:0];
    else                   res_d = v[31:0];
  end

  // Pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    s2_q  <= s2_d;
    res_q <= res_d;
  end

  assign done_o      = v3_q;
  assign quantized_o = res_q;

  // Checks
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o) else $error("latency");
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && s2_q.nan) |=> (quantized_o == 32'd0)) else $error("nan");
  a_s8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && mode_q == MODE_S8) |=> ($signed(quantized_o) <= 127 &&
     $signed(quantized_o) >= -128)) else $error("s8 range");

endmodule
